>>> sv/wsdf_pkg.sv
package wsdf_pkg;

	localparam int unsigned LENGTH_BITS_DEFAULT = 32;
	localparam int unsigned TDATA_W = 16;
	localparam int unsigned TUSER_W = 3;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXTLEN,
		PH_MASK,
		PH_PAYLOAD
	} phase_t;

	// Frame opcodes.
	localparam logic [3:0] OP_CONT  = 4'h0;
	localparam logic [3:0] OP_TEXT  = 4'h1;
	localparam logic [3:0] OP_BIN   = 4'h2;
	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;
	localparam logic [3:0] OP_PONG  = 4'hA;

	// Message types.
	localparam logic [2:0] MT_TEXT     = 3'd0;
	localparam logic [2:0] MT_BINARY   = 3'd1;
	localparam logic [2:0] MT_CLOSE    = 3'd2;
	localparam logic [2:0] MT_PING     = 3'd3;
	localparam logic [2:0] MT_PONG     = 3'd4;
	localparam logic [2:0] MT_RESERVED = 3'd5;

	// Actions requested at the end of a message.
	localparam logic [2:0] ACT_NONE       = 3'd0;
	localparam logic [2:0] ACT_DELIVER    = 3'd1;
	localparam logic [2:0] ACT_PONG       = 3'd2;
	localparam logic [2:0] ACT_CLOSE_1000 = 3'd3;
	localparam logic [2:0] ACT_CLOSE_1002 = 3'd4;
	localparam logic [2:0] ACT_IGNORE     = 3'd5;

	// Seven-bit length codes that announce an extended length.
	localparam logic [6:0] LEN7_EXT16 = 7'd126;
	localparam logic [6:0] LEN7_EXT64 = 7'd127;

	// Remaining header bytes minus one, loaded into the header counter.
	localparam logic [2:0] EXT16_CNT = 3'd1;
	localparam logic [2:0] EXT64_CNT = 3'd7;
	localparam logic [2:0] MASK_CNT  = 3'd3;

	typedef struct packed {
		logic [2:0] action;
		logic       end_of_message;
		logic [2:0] message_type;
		logic       byte_valid;
		logic [7:0] payload_byte;
	} result_t;

	function automatic logic [2:0] type_of(input logic [3:0] op);
		logic [2:0] t;
		case (op)
			OP_TEXT:  t = MT_TEXT;
			OP_BIN:   t = MT_BINARY;
			OP_CLOSE: t = MT_CLOSE;
			OP_PING:  t = MT_PING;
			OP_PONG:  t = MT_PONG;
			default:  t = MT_RESERVED;
		endcase
		return t;
	endfunction

	function automatic logic [2:0] action_of(input logic [3:0] op);
		logic [2:0] a;
		case (op)
			OP_TEXT:  a = ACT_DELIVER;
			OP_CLOSE: a = ACT_CLOSE_1000;
			OP_PING:  a = ACT_PONG;
			default:  a = ACT_IGNORE;
		endcase
		return a;
	endfunction

endpackage

>>> sv/websocket_frame_deframer.sv
// WebSocket receive-side deframer.
// The slave channel takes the received stream one byte per item (tdata[7:0]).
// Header bytes are parsed (FIN, opcode, mask bit, 7/16/64-bit length, mask key)
// and produce no result, except an empty final or dropped frame, which yields one result
// on its last header byte. Payload bytes of frames not dropped leave on the
// master channel unmasked, with the message type on tuser; tlast marks the
// result that ends a message or a dropped frame, and that result carries the
// action the endpoint takes. A result is registered in the output register,
// or in the skid register while the output is held. One item is accepted
// every cycle while tready is high; the header parser updates on acceptance.
// A one-entry skid register behind the output register keeps tready high for
// one more item while a result waits; tready drops only when both hold data,
// and a stalled receiver loses nothing. Long lengths keep the low LENGTH_BITS.
// Reset empties both registers, clears the fragment state and puts the parser
// in front of the first header byte of a frame.
module websocket_frame_deframer #(
	parameter int unsigned LENGTH_BITS = wsdf_pkg::LENGTH_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [7:0]                   s_axis_tdata,  // [7:0] rx_byte
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	// [7:0] payload_byte, [8] byte_valid, [11:9] action, [15:12] zero
	output logic [wsdf_pkg::TDATA_W-1:0] m_axis_tdata,
	output logic [wsdf_pkg::TUSER_W-1:0] m_axis_tuser,  // [2:0] message_type
	output logic                         m_axis_tlast   // end_of_message
);

	wsdf_pkg::phase_t        phase_q, phase_d;
	logic [2:0]              cnt_q, cnt_d;
	logic                    final_q, final_d;
	logic [3:0]              opcode_q, opcode_d;
	logic                    masked_q, masked_d;
	logic [LENGTH_BITS-1:0]  remain_q, remain_d;
	logic [31:0]             key_q, key_d;
	logic [1:0]              mpos_q, mpos_d;
	logic                    frag_q, frag_d;
	logic [3:0]              saved_q, saved_d;
	logic                    discard_q, discard_d;

	logic                    accept;
	logic [7:0]              b;
	logic [6:0]              len7;
	logic [LENGTH_BITS-1:0]  len7_ext;
	logic [LENGTH_BITS-1:0]  remain_shift;
	logic [3:0]              eff_op;
	logic [7:0]              key_byte;
	logic [7:0]              unmasked;

	logic                    res_valid;
	wsdf_pkg::result_t       res;

	logic                    out_valid_q;
	wsdf_pkg::result_t       out_q;
	logic                    skid_valid_q;
	wsdf_pkg::result_t       skid_q;
	logic                    out_take;

	assign accept       = s_axis_tvalid && s_axis_tready;
	assign b            = s_axis_tdata;
	assign len7         = b[6:0];
	assign len7_ext     = LENGTH_BITS'(len7);
	assign remain_shift = {remain_q[LENGTH_BITS-9:0], b};
	assign eff_op       = (opcode_q != wsdf_pkg::OP_CONT) ? opcode_q : saved_q;

	always_comb begin
		case (mpos_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	assign unmasked = masked_q ? (b ^ key_byte) : b;

	// Next-state logic of the header parser.
	always_comb begin
		phase_d   = phase_q;
		cnt_d     = cnt_q;
		final_d   = final_q;
		opcode_d  = opcode_q;
		masked_d  = masked_q;
		remain_d  = remain_q;
		key_d     = key_q;
		mpos_d    = mpos_q;
		frag_d    = frag_q;
		saved_d   = saved_q;
		discard_d = discard_q;
		case (phase_q)
			wsdf_pkg::PH_HDR0: begin
				final_d   = b[7];
				opcode_d  = b[3:0];
				discard_d = 1'b0;
				// A continuation needs an open message, a new opcode must not have one.
				if ((b[3:0] != wsdf_pkg::OP_CONT) == frag_q) begin
					discard_d = 1'b1;
					frag_d    = 1'b0;
				end else if (b[3:0] != wsdf_pkg::OP_CONT) begin
					if (!b[7]) begin
						frag_d  = 1'b1;
						saved_d = b[3:0];
					end
				end else if (b[7]) begin
					frag_d = 1'b0;
				end
				phase_d = wsdf_pkg::PH_HDR1;
			end
			wsdf_pkg::PH_HDR1: begin
				masked_d = b[7];
				key_d    = '0;
				remain_d = '0;
				if (len7 == wsdf_pkg::LEN7_EXT16 || len7 == wsdf_pkg::LEN7_EXT64) begin
					cnt_d   = (len7 == wsdf_pkg::LEN7_EXT16) ? wsdf_pkg::EXT16_CNT
					                                         : wsdf_pkg::EXT64_CNT;
					phase_d = wsdf_pkg::PH_EXTLEN;
				end else begin
					remain_d = len7_ext;
					if (b[7]) begin
						cnt_d   = wsdf_pkg::MASK_CNT;
						phase_d = wsdf_pkg::PH_MASK;
					end else begin
						cnt_d   = '0;
						mpos_d  = '0;
						phase_d = (len7 == '0) ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_PAYLOAD;
					end
				end
			end
			wsdf_pkg::PH_EXTLEN: begin
				remain_d = remain_shift;
				if (cnt_q == '0) begin
					if (masked_q) begin
						cnt_d   = wsdf_pkg::MASK_CNT;
						phase_d = wsdf_pkg::PH_MASK;
					end else begin
						mpos_d  = '0;
						phase_d = (remain_shift == '0) ? wsdf_pkg::PH_HDR0
						                               : wsdf_pkg::PH_PAYLOAD;
					end
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			wsdf_pkg::PH_MASK: begin
				key_d = {key_q[23:0], b};
				if (cnt_q == '0) begin
					mpos_d  = '0;
					phase_d = (remain_q == '0) ? wsdf_pkg::PH_HDR0 : wsdf_pkg::PH_PAYLOAD;
				end else begin
					cnt_d = cnt_q - 3'd1;
				end
			end
			wsdf_pkg::PH_PAYLOAD: begin
				mpos_d   = mpos_q + 2'd1;
				remain_d = remain_q - LENGTH_BITS'(1);
				if (remain_q == LENGTH_BITS'(1)) begin
					phase_d = wsdf_pkg::PH_HDR0;
				end
			end
			default: begin
				phase_d = wsdf_pkg::PH_HDR0;
			end
		endcase
	end

	// Result logic: one result at most per accepted byte.
	always_comb begin
		logic finish;
		logic has_byte;
		finish    = 1'b0;
		has_byte  = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		case (phase_q)
			wsdf_pkg::PH_HDR1: begin
				finish = !b[7] && len7 == '0;
			end
			wsdf_pkg::PH_EXTLEN: begin
				finish = cnt_q == '0 && !masked_q && remain_shift == '0;
			end
			wsdf_pkg::PH_MASK: begin
				finish = cnt_q == '0 && remain_q == '0;
			end
			wsdf_pkg::PH_PAYLOAD: begin
				finish   = remain_q == LENGTH_BITS'(1);
				has_byte = 1'b1;
			end
			default: begin
				finish = 1'b0;
			end
		endcase

		if (finish) begin
			if (discard_q) begin
				res_valid          = 1'b1;
				res.message_type   = wsdf_pkg::MT_RESERVED;
				res.end_of_message = 1'b1;
				res.action         = wsdf_pkg::ACT_CLOSE_1002;
			end else if (final_q) begin
				res_valid          = 1'b1;
				res.payload_byte   = has_byte ? unmasked : 8'd0;
				res.byte_valid     = has_byte;
				res.message_type   = wsdf_pkg::type_of(eff_op);
				res.end_of_message = 1'b1;
				res.action         = wsdf_pkg::action_of(eff_op);
			end else if (has_byte) begin
				res_valid        = 1'b1;
				res.payload_byte = unmasked;
				res.byte_valid   = 1'b1;
				res.message_type = wsdf_pkg::type_of(eff_op);
			end
		end else if (has_byte && !discard_q) begin
			res_valid        = 1'b1;
			res.payload_byte = unmasked;
			res.byte_valid   = 1'b1;
			res.message_type = wsdf_pkg::type_of(eff_op);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsdf_pkg::PH_HDR0;
			cnt_q     <= '0;
			final_q   <= 1'b0;
			opcode_q  <= '0;
			masked_q  <= 1'b0;
			remain_q  <= '0;
			key_q     <= '0;
			mpos_q    <= '0;
			frag_q    <= 1'b0;
			saved_q   <= '0;
			discard_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_d;
			cnt_q     <= cnt_d;
			final_q   <= final_d;
			opcode_q  <= opcode_d;
			masked_q  <= masked_d;
			remain_q  <= remain_d;
			key_q     <= key_d;
			mpos_q    <= mpos_d;
			frag_q    <= frag_d;
			saved_q   <= saved_d;
			discard_q <= discard_d;
		end
	end

	// Output register with a one-entry skid behind it.
	assign out_take      = out_valid_q && m_axis_tready;
	assign s_axis_tready = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_take) begin
				skid_valid_q <= 1'b0;
			end
		end else if (!out_valid_q || out_take) begin
			out_valid_q <= accept && res_valid;
		end else if (accept && res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_q <= skid_q;
			end
		end else if (!out_valid_q || out_take) begin
			if (accept && res_valid) begin
				out_q <= res;
			end
		end else if (accept && res_valid) begin
			skid_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.action, out_q.byte_valid, out_q.payload_byte};
	assign m_axis_tuser  = out_q.message_type;
	assign m_axis_tlast  = out_q.end_of_message;

	// The skid entry is only ever filled behind a held output.
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid while output register is empty");

	// An action is only requested on the result that ends a message.
	a_action_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[11:9] != wsdf_pkg::ACT_NONE) |-> m_axis_tlast)
		else $error("action without end of message");

	// The payload phase always has bytes left to consume.
	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == wsdf_pkg::PH_PAYLOAD) |-> (remain_q != '0))
		else $error("payload phase with no bytes remaining");

	// A dropped frame ends with a close 1002 request and no payload byte.
	a_discard_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res_valid && discard_q) |->
			(res.action == wsdf_pkg::ACT_CLOSE_1002 && !res.byte_valid))
		else $error("dropped frame produced a payload result");

endmodule
